@@ rtl/ccas_pkg.sv @@
// ---------------------------------------------------------------------------
// ccas_pkg
// Shared types and constants for the cyclic cellular automaton step core.
// ---------------------------------------------------------------------------
package ccas_pkg;

   // request codes
   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_STEP = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_RANGE     = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_STATES    = 2'd2;
   localparam logic [1:0] CSR_MOORE     = 2'd3;

   localparam int CELL_W  = 5;
   localparam int CSR_W   = 7;
   localparam int RANGE_W = 3;
   localparam int THR_W   = 7;
   localparam int SC_W    = 6;

   // reset values of the configuration registers
   localparam logic [RANGE_W-1:0] RANGE_RST = 3'd1;
   localparam logic [THR_W-1:0]   THR_RST   = 7'd1;
   localparam logic [SC_W-1:0]    SC_RST    = 6'd4;

   // controller to datapath commands
   typedef struct packed {
      logic clr_en;    // clear one cell after reset
      logic load_en;   // load request accepted
      logic read_en;   // read request accepted
      logic rd_out;    // present read data on the response register
      logic init_en;   // set up neighbourhood walk for current cell
      logic base_en;   // compute row base, fetch center cell
      logic scan_en;   // fetch one neighbour
      logic write_en;  // store updated cell in work copy
      logic copy_en;   // copy one cell back from work copy
      logic done_en;   // present step completion
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic scan_last;
      logic cell_last;
      logic copy_last;
      logic rsp_free;
   } status_type;

endpackage

@@ rtl/ccas_ram.sv @@
// ---------------------------------------------------------------------------
// ccas_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module ccas_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

@@ rtl/ccas_ctrl.sv @@
// ---------------------------------------------------------------------------
// ccas_ctrl
// Sequencer: reset clear pass, load/read requests, and the generation walk
// (per cell: setup, center fetch, neighbour scan, update), then copy-back.
// ---------------------------------------------------------------------------
module ccas_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  ccas_pkg::status_type status,
   output ccas_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_RD_OUT = 4'd2;
   localparam logic [3:0] S_INIT   = 4'd3;
   localparam logic [3:0] S_BASE   = 4'd4;
   localparam logic [3:0] S_SCAN   = 4'd5;
   localparam logic [3:0] S_DRAIN  = 4'd6;
   localparam logic [3:0] S_WRITE  = 4'd7;
   localparam logic [3:0] S_COPY   = 4'd8;
   localparam logic [3:0] S_CDRAIN = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               case (req_type)
                  ccas_pkg::REQ_LOAD: cmd.load_en = 1'b1;
                  ccas_pkg::REQ_READ: begin
                     cmd.read_en = 1'b1;
                     state_in    = S_RD_OUT;
                  end
                  ccas_pkg::REQ_STEP: state_in = S_INIT;
                  default: ;
               endcase
            end
         end
         S_RD_OUT: begin
            if (status.rsp_free) begin
               cmd.rd_out = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_INIT: begin
            cmd.init_en = 1'b1;
            state_in    = S_BASE;
         end
         S_BASE: begin
            cmd.base_en = 1'b1;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_en = 1'b1;
            if (status.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_WRITE;
         S_WRITE: begin
            cmd.write_en = 1'b1;
            state_in     = status.cell_last ? S_COPY : S_INIT;
         end
         S_COPY: begin
            cmd.copy_en = 1'b1;
            if (status.copy_last) state_in = S_CDRAIN;
         end
         S_CDRAIN: state_in = S_DONE;
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.done_en = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/ccas_dp.sv @@
// ---------------------------------------------------------------------------
// ccas_dp
// Datapath: configuration registers, grid and work-copy memories, the
// neighborhood walk counters, successor counter and response register.
// ---------------------------------------------------------------------------
module ccas_dp #(
   parameter int GRID_COLS = 64,
   parameter int GRID_ROWS = 64,
   parameter int MAX_RANGE = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [ccas_pkg::CSR_W-1:0]     csr_wdata,
   input  logic [11:0]                    req_cell_index,
   input  logic [ccas_pkg::CELL_W-1:0]    req_cell_value,
   input  ccas_pkg::cmd_type              cmd,
   output ccas_pkg::status_type           status,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ccas_pkg::CELL_W-1:0]    rsp_read_value,
   output logic                           rsp_step_done
);

   localparam int TOTAL = GRID_COLS * GRID_ROWS;
   localparam int COL_W = $clog2(GRID_COLS);
   localparam int ROW_W = $clog2(GRID_ROWS);
   localparam int IDX_W = $clog2(TOTAL);
   localparam int LIM_W = (IDX_W + 1 > 12) ? IDX_W + 1 : 12;
   localparam int RNG_W = $clog2(MAX_RANGE + 1);
   localparam int OFF_W = RNG_W + 1;
   localparam int CNT_W = $clog2((2 * MAX_RANGE + 1) * (2 * MAX_RANGE + 1) + 1);
   localparam int CMP_W = (CNT_W > ccas_pkg::THR_W) ? CNT_W : ccas_pkg::THR_W;
   localparam int CW    = ccas_pkg::CELL_W;

   // configuration
   logic [ccas_pkg::RANGE_W-1:0] range_ff;
   logic [ccas_pkg::THR_W-1:0]   thr_ff;
   logic [ccas_pkg::SC_W-1:0]    sc_ff;
   logic                         moore_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= ccas_pkg::RANGE_RST;
         thr_ff   <= ccas_pkg::THR_RST;
         sc_ff    <= ccas_pkg::SC_RST;
         moore_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            ccas_pkg::CSR_RANGE:     range_ff <= csr_wdata[ccas_pkg::RANGE_W-1:0];
            ccas_pkg::CSR_THRESHOLD: thr_ff   <= csr_wdata[ccas_pkg::THR_W-1:0];
            ccas_pkg::CSR_STATES:    sc_ff    <= csr_wdata[ccas_pkg::SC_W-1:0];
            ccas_pkg::CSR_MOORE:     moore_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective radius, saturated
   logic [RNG_W-1:0] range_eff;
   assign range_eff = ({1'b0, range_ff} > 4'(MAX_RANGE)) ? RNG_W'(MAX_RANGE)
                                                         : RNG_W'(range_ff);
   logic signed [OFF_W-1:0] r_pos;
   assign r_pos = $signed({1'b0, range_eff});

   // request address
   logic [LIM_W-1:0] req_wide;
   logic [IDX_W-1:0] req_addr;
   logic             req_in_grid;
   assign req_wide    = LIM_W'(req_cell_index);
   assign req_addr    = req_wide[IDX_W-1:0];
   assign req_in_grid = req_wide < LIM_W'(TOTAL);

   // walk registers
   logic [IDX_W-1:0]        cell_idx_ff, base_ff, ptr_ff, ptr_d_ff;
   logic [COL_W-1:0]        x_ff, nx_ff, nx_start_ff;
   logic [ROW_W-1:0]        y_ff, ny_ff;
   logic signed [OFF_W-1:0] dx_ff, dy_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [CW-1:0]           center_ff;
   logic                    center_pend_ff, nb_pend_ff, incl_ff, copy_pend_ff, rd_oob_ff;

   logic [CW-1:0] cell_rdata, next_rdata;

   // wrapped start coordinates
   logic [COL_W:0]   xe, re_c;
   logic [ROW_W:0]   ye, re_r;
   logic [COL_W-1:0] nx_init;
   logic [ROW_W-1:0] ny_init;
   assign xe   = {1'b0, x_ff};
   assign ye   = {1'b0, y_ff};
   assign re_c = (COL_W + 1)'(range_eff);
   assign re_r = (ROW_W + 1)'(range_eff);
   assign nx_init = (xe >= re_c) ? COL_W'(xe - re_c)
                                 : COL_W'(xe + (COL_W + 1)'(GRID_COLS) - re_c);
   assign ny_init = (ye >= re_r) ? ROW_W'(ye - re_r)
                                 : ROW_W'(ye + (ROW_W + 1)'(GRID_ROWS) - re_r);

   // neighborhood membership of the current offset
   logic [OFF_W-1:0] adx, ady;
   logic [OFF_W:0]   man_dist;
   logic             incl;
   assign adx      = dx_ff[OFF_W-1] ? OFF_W'(-dx_ff) : OFF_W'(dx_ff);
   assign ady      = dy_ff[OFF_W-1] ? OFF_W'(-dy_ff) : OFF_W'(dy_ff);
   assign man_dist = {1'b0, adx} + {1'b0, ady};
   assign incl     = moore_ff ||
                     ((man_dist <= (OFF_W + 1)'(range_eff)) && (man_dist != '0));

   logic dx_end, dy_end, nx_end, ny_end;
   assign dx_end = (dx_ff == r_pos);
   assign dy_end = (dy_ff == r_pos);
   assign nx_end = (nx_ff == COL_W'(GRID_COLS - 1));
   assign ny_end = (ny_ff == ROW_W'(GRID_ROWS - 1));

   // successor test and advance value
   logic [ccas_pkg::SC_W-1:0] top;
   logic                      eq_top, ge_top, is_succ, advance;
   logic [CW-1:0]             new_val;
   assign top     = sc_ff - ccas_pkg::SC_W'(1);
   assign eq_top  = (sc_ff != '0) && ({1'b0, center_ff} == top);
   assign ge_top  = (sc_ff == '0) || ({1'b0, center_ff} >= top);
   assign is_succ = eq_top ? (cell_rdata == '0)
                           : ({1'b0, cell_rdata} == ({1'b0, center_ff} + 6'd1));
   assign advance = CMP_W'(count_ff) >= CMP_W'(thr_ff);
   assign new_val = !advance ? center_ff : (ge_top ? '0 : center_ff + CW'(1));

   // walk sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_idx_ff <= '0;
         x_ff        <= '0;
         y_ff        <= '0;
         ptr_ff      <= '0;
      end else begin
         if (cmd.init_en) begin
            dx_ff       <= -r_pos;
            dy_ff       <= -r_pos;
            nx_ff       <= nx_init;
            nx_start_ff <= nx_init;
            ny_ff       <= ny_init;
            count_ff    <= '0;
         end
         if (cmd.base_en) begin
            base_ff <= IDX_W'(ny_ff) * IDX_W'(GRID_COLS);
         end
         if (cmd.scan_en) begin
            if (dx_end) begin
               dx_ff   <= -r_pos;
               nx_ff   <= nx_start_ff;
               dy_ff   <= dy_ff + OFF_W'(1);
               ny_ff   <= ny_end ? '0 : ny_ff + ROW_W'(1);
               base_ff <= ny_end ? '0 : base_ff + IDX_W'(GRID_COLS);
            end else begin
               dx_ff <= dx_ff + OFF_W'(1);
               nx_ff <= nx_end ? '0 : nx_ff + COL_W'(1);
            end
         end
         if (nb_pend_ff && incl_ff && is_succ) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (center_pend_ff) begin
            center_ff <= cell_rdata;
         end
         // next cell in row-major order
         if (cmd.write_en) begin
            cell_idx_ff <= status.cell_last ? '0 : cell_idx_ff + IDX_W'(1);
            if (x_ff == COL_W'(GRID_COLS - 1)) begin
               x_ff <= '0;
               y_ff <= (y_ff == ROW_W'(GRID_ROWS - 1)) ? '0 : y_ff + ROW_W'(1);
            end else begin
               x_ff <= x_ff + COL_W'(1);
            end
         end
         // clear and copy sweeps
         if (cmd.clr_en || cmd.copy_en) begin
            ptr_ff <= (ptr_ff == IDX_W'(TOTAL - 1)) ? '0 : ptr_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_pend_ff <= 1'b0;
         nb_pend_ff     <= 1'b0;
         copy_pend_ff   <= 1'b0;
      end else begin
         center_pend_ff <= cmd.base_en;
         nb_pend_ff     <= cmd.scan_en;
         copy_pend_ff   <= cmd.copy_en;
      end
      incl_ff  <= incl;
      ptr_d_ff <= ptr_ff;
      if (cmd.read_en) rd_oob_ff <= !req_in_grid;
   end

   // grid memory ports
   logic             g_we, g_re;
   logic [IDX_W-1:0] g_waddr, g_raddr;
   logic [CW-1:0]    g_wdata;

   always_comb begin
      g_we    = 1'b0;
      g_waddr = ptr_ff;
      g_wdata = '0;
      if (cmd.clr_en) begin
         g_we = 1'b1;
      end else if (cmd.load_en && req_in_grid) begin
         g_we    = 1'b1;
         g_waddr = req_addr;
         g_wdata = req_cell_value;
      end else if (copy_pend_ff) begin
         g_we    = 1'b1;
         g_waddr = ptr_d_ff;
         g_wdata = next_rdata;
      end
      g_re    = cmd.read_en || cmd.base_en || cmd.scan_en;
      g_raddr = cmd.read_en ? req_addr
              : (cmd.base_en ? cell_idx_ff : base_ff + IDX_W'(nx_ff));
   end

   ccas_ram #(.WIDTH(CW), .DEPTH(TOTAL)) u_cell_grid (
      .clock    (clock),
      .we       (g_we),
      .waddr    (g_waddr),
      .wdata    (g_wdata),
      .re       (g_re),
      .raddr    (g_raddr),
      .rdata_ff (cell_rdata)
   );

   ccas_ram #(.WIDTH(CW), .DEPTH(TOTAL)) u_next_grid (
      .clock    (clock),
      .we       (cmd.write_en),
      .waddr    (cell_idx_ff),
      .wdata    (new_val),
      .re       (cmd.copy_en),
      .raddr    (ptr_ff),
      .rdata_ff (next_rdata)
   );

   // response register
   logic          rsp_valid_ff;
   logic [CW-1:0] rsp_value_ff;
   logic          rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rd_out || cmd.done_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rd_out) begin
         rsp_value_ff <= rd_oob_ff ? '0 : cell_rdata;
         rsp_done_ff  <= 1'b0;
      end else if (cmd.done_en) begin
         rsp_value_ff <= '0;
         rsp_done_ff  <= 1'b1;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_step_done  = rsp_done_ff;

   assign status.clear_last = (ptr_ff == IDX_W'(TOTAL - 1));
   assign status.copy_last  = (ptr_ff == IDX_W'(TOTAL - 1));
   assign status.scan_last  = dx_end && dy_end;
   assign status.cell_last  = (cell_idx_ff == IDX_W'(TOTAL - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

@@ rtl/cyclic_cellular_automaton_step_core.sv @@
// ---------------------------------------------------------------------------
// cyclic_cellular_automaton_step_core
// Toroidal cyclic cellular automaton: load, read and one-generation step.
// ---------------------------------------------------------------------------
//   channel  signals                                    direction
//   req      req_valid/ready, req_type, req_cell_index,  in
//            req_cell_value
//   rsp      rsp_valid/ready, rsp_read_value,            out
//            rsp_step_done
//   csr      csr_we, csr_index, csr_wdata                in
//
// Load: the value is written to the grid when the request is accepted. Read: the
// grid read data is registered, then moved to the response register once it is free.
// Step: per cell, setup, center fetch, a fetch of every offset of the square
// (2R+1)x(2R+1) through the single grid read port (R = saturated range), a drain
// and a write to the work grid; then the work grid is copied back and the
// completion goes to the response register. After reset a clear pass runs; req_ready low.
// A stalled response holds the controller before it leaves the read/done step.
// ---------------------------------------------------------------------------
module cyclic_cellular_automaton_step_core #(
   parameter int GRID_COLS = 64,
   parameter int GRID_ROWS = 64,
   parameter int MAX_RANGE = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_type,
   input  logic [11:0]                 req_cell_index,
   input  logic [ccas_pkg::CELL_W-1:0] req_cell_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ccas_pkg::CELL_W-1:0] rsp_read_value,
   output logic                        rsp_step_done,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [ccas_pkg::CSR_W-1:0]  csr_wdata
);

   ccas_pkg::cmd_type    cmd;
   ccas_pkg::status_type status;

   ccas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .status    (status),
      .cmd       (cmd)
   );

   ccas_dp #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS),
      .MAX_RANGE (MAX_RANGE)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_cell_index (req_cell_index),
      .req_cell_value (req_cell_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_step_done  (rsp_step_done)
   );

`ifndef NO_ASSERTIONS
   // a step completion always carries a zero read value
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_done |-> rsp_read_value == '0)
      else $error("step completion with nonzero read value");

   // single grid read port: one user at a time
   a_read_port: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.read_en, cmd.base_en, cmd.scan_en}))
      else $error("grid read port conflict");

   // no request taken during a neighbour scan, copy-back or reset clear pass
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_en || cmd.copy_en || cmd.clr_en |-> !req_ready)
      else $error("request ready during walk");
`endif

endmodule

@@ verif/tb_cyclic_cellular_automaton_step_core.sv @@
// ---------------------------------------------------------------------------
// tb_cyclic_cellular_automaton_step_core
// Self-checking regression for the cyclic cellular automaton step core.
// A behavioral grid model predicts every read and step response. Responses
// are checked in order against the pending queue. Traffic goes out in bursts
// and the response side stalls on its own pattern. Configuration is changed
// only while the core is idle.
// ---------------------------------------------------------------------------
module tb_cyclic_cellular_automaton_step_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS        = 64;
   localparam int ROWS        = 64;
   localparam int CELLS       = COLS * ROWS;
   localparam int RANGE_CAP   = 5;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int CW          = ccas_pkg::CELL_W;
   localparam int CSRW        = ccas_pkg::CSR_W;
   localparam int RW          = ccas_pkg::RANGE_W;
   localparam int TW          = ccas_pkg::THR_W;
   localparam int SW          = ccas_pkg::SC_W;
   // request code the core drops without a response
   localparam logic [1:0] REQ_NONE = 2'd3;

   typedef struct {
      logic [CW-1:0] value;
      logic          done;
   } exp_rsp_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   logic [1:0]      req_type = ccas_pkg::REQ_LOAD;
   logic [11:0]     req_cell_index = '0;
   logic [CW-1:0]   req_cell_value = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic [CW-1:0]   rsp_read_value;
   logic            rsp_step_done;
   logic            csr_we = 1'b0;
   logic [1:0]      csr_index = ccas_pkg::CSR_RANGE;
   logic [CSRW-1:0] csr_wdata = '0;

   // grid model and its configuration
   logic [CW-1:0] grid_model [CELLS];
   logic [RW-1:0] cfg_range;
   logic [TW-1:0] cfg_threshold;
   logic [SW-1:0] cfg_states;
   logic          cfg_moore;

   exp_rsp_type pending_rsp [$];
   int   error_count = 0;
   int   cycle_count = 0;
   // sender burst state
   int   burst_left = 0;
   int   gap_max = 0;

   cyclic_cellular_automaton_step_core #(
      .GRID_COLS(COLS), .GRID_ROWS(ROWS), .MAX_RANGE(RANGE_CAP)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_cell_index(req_cell_index), .req_cell_value(req_cell_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_read_value(rsp_read_value), .rsp_step_done(rsp_step_done),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cyclic_cellular_automaton_step_core regression: fail");
         $finish;
      end
   end

   // response stall pattern: a randomly drawn mode, re-drawn periodically, sets rsp_ready
   int stall_mode = 0;
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= stall_phase[0];
         2: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= (stall_phase % 16) > 11;
      endcase
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      exp_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response, step_done", int'(rsp_step_done), 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_read_value !== want.value)
               report_mismatch("read_value", int'(rsp_read_value), int'(want.value));
            if (rsp_step_done !== want.done)
               report_mismatch("step_done", int'(rsp_step_done), int'(want.done));
         end
      end
   end

   // one generation on the model, judged on the grid before the step
   function automatic void advance_generation();
      logic [CW-1:0] next_cells [CELLS];
      int r, top, x, y, dx, dy, ax, ay, own_val, other, hits, nx, ny;
      r   = (cfg_range > RANGE_CAP) ? RANGE_CAP : int'(cfg_range);
      top = int'(cfg_states) - 1;
      for (y = 0; y < ROWS; y++) begin
         for (x = 0; x < COLS; x++) begin
            own_val = grid_model[y*COLS + x];
            hits = 0;
            for (dx = -r; dx <= r; dx++) begin
               for (dy = -r; dy <= r; dy++) begin
                  ax = dx < 0 ? -dx : dx;
                  ay = dy < 0 ? -dy : dy;
                  if (!cfg_moore && (ax + ay > r || ax + ay == 0)) continue;
                  nx = (x + dx + COLS) % COLS;
                  ny = (y + dy + ROWS) % ROWS;
                  other = grid_model[ny*COLS + nx];
                  if (own_val == top ? other == 0 : other == own_val + 1) hits++;
               end
            end
            if (hits >= int'(cfg_threshold))
               next_cells[y*COLS + x] = (own_val >= top) ? '0 : CW'(own_val + 1);
            else
               next_cells[y*COLS + x] = CW'(own_val);
         end
      end
      grid_model = next_cells;
   endfunction

   // send one request; valid stays up into the next request inside a burst
   task automatic send_request(input logic [1:0] kind, input int idx, input int val);
      exp_rsp_type want;
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_cell_index <= 12'(idx);
      req_cell_value <= CW'(val);
      do @(posedge clock); while (!req_ready);
      case (kind)
         ccas_pkg::REQ_LOAD: grid_model[idx] = CW'(val);
         ccas_pkg::REQ_STEP: begin
            advance_generation();
            want.value = '0;
            want.done  = 1'b1;
            pending_rsp.push_back(want);
         end
         ccas_pkg::REQ_READ: begin
            want.value = grid_model[idx];
            want.done  = 1'b0;
            pending_rsp.push_back(want);
         end
         default: ;
      endcase
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if (gap_max > 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end
   endtask

   // drop valid and wait until every response is back, plus load latency
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_config(input int range_v, input int thr_v, input int sc_v,
                               input int moore_v);
      req_valid <= 1'b0;
      csr_we <= 1'b1;
      csr_index <= ccas_pkg::CSR_RANGE;     csr_wdata <= CSRW'(range_v); @(posedge clock);
      csr_index <= ccas_pkg::CSR_THRESHOLD; csr_wdata <= CSRW'(thr_v);   @(posedge clock);
      csr_index <= ccas_pkg::CSR_STATES;    csr_wdata <= CSRW'(sc_v);    @(posedge clock);
      csr_index <= ccas_pkg::CSR_MOORE;     csr_wdata <= CSRW'(moore_v); @(posedge clock);
      csr_we <= 1'b0;
      cfg_range     = RW'(range_v);
      cfg_threshold = TW'(thr_v);
      cfg_states    = SW'(sc_v);
      cfg_moore     = moore_v[0];
      @(posedge clock);
   endtask

   // field extremes, unknown request type, reads after reset
   task automatic test_field_extremes();
      gap_max = 0;
      send_request(ccas_pkg::REQ_READ, 0, 0);
      send_request(ccas_pkg::REQ_READ, CELLS - 1, 31);
      send_request(ccas_pkg::REQ_LOAD, 0, 31);
      send_request(ccas_pkg::REQ_LOAD, CELLS - 1, 21);
      send_request(ccas_pkg::REQ_LOAD, 2730, 10);
      send_request(REQ_NONE, 0, 5);
      send_request(REQ_NONE, CELLS - 1, 31);
      send_request(ccas_pkg::REQ_READ, 0, 0);
      send_request(ccas_pkg::REQ_READ, CELLS - 1, 0);
      send_request(ccas_pkg::REQ_READ, 2730, 0);
      wait_idle();
   endtask

   // generation steps across the corner cases of the rules
   task automatic test_generation_rules();
      // reset config, wrap across both edges: corner cell sees the opposite corner
      send_request(ccas_pkg::REQ_LOAD, 0, 0);
      send_request(ccas_pkg::REQ_LOAD, CELLS - 1, 1);
      send_request(ccas_pkg::REQ_LOAD, COLS - 1, 1);
      send_request(ccas_pkg::REQ_STEP, 0, 0);
      send_request(ccas_pkg::REQ_READ, 0, 0);
      send_request(ccas_pkg::REQ_READ, CELLS - 1, 0);
      wait_idle();
      // zero range, von Neumann, zero threshold, zero state count: all to 0
      write_config(0, 0, 0, 0);
      send_request(ccas_pkg::REQ_STEP, 0, 0);
      send_request(ccas_pkg::REQ_READ, 0, 0);
      send_request(ccas_pkg::REQ_READ, 2730, 0);
      wait_idle();
      // oversized range saturates; top threshold, 32 states, diamond
      send_request(ccas_pkg::REQ_LOAD, 100, 7);
      send_request(ccas_pkg::REQ_LOAD, 101, 8);
      write_config(7, 121, 32, 0);
      send_request(ccas_pkg::REQ_STEP, 0, 0);
      send_request(ccas_pkg::REQ_READ, 100, 0);
      wait_idle();
      // state count above 32: 31 wraps to 0; values above the top with 3 states
      send_request(ccas_pkg::REQ_LOAD, 5, 31);
      send_request(ccas_pkg::REQ_LOAD, 6, 2);
      write_config(1, 0, 63, 1);
      send_request(ccas_pkg::REQ_STEP, 0, 0);
      send_request(ccas_pkg::REQ_READ, 5, 0);
      wait_idle();
      send_request(ccas_pkg::REQ_LOAD, 7, 5);
      send_request(ccas_pkg::REQ_LOAD, 8, 2);
      write_config(1, 0, 3, 1);
      send_request(ccas_pkg::REQ_STEP, 0, 0);
      send_request(ccas_pkg::REQ_READ, 7, 0);
      send_request(ccas_pkg::REQ_READ, 8, 0);
      wait_idle();
   endtask

   // random loads and reads with a step per phase; cheap ranges only
   task automatic test_random_traffic();
      int phase, n, idx, last_idx, roll;
      last_idx = 0;
      for (phase = 0; phase < 3; phase++) begin
         write_config($urandom_range(0, 1), $urandom_range(0, 9),
                      (phase == 0) ? 1 : $urandom_range(2, 63), $urandom_range(0, 1));
         gap_max = (phase == 1) ? 0 : $urandom_range(1, 6);
         for (n = 0; n < 580; n++) begin
            roll = $urandom_range(0, 99);
            idx  = $urandom_range(0, CELLS - 1);
            if (roll < 3) send_request(REQ_NONE, idx, $urandom_range(0, 31));
            else if (roll < 48) begin
               send_request(ccas_pkg::REQ_LOAD, idx, $urandom_range(0, 31));
               last_idx = idx;
            end else if (roll < 75) begin
               send_request(ccas_pkg::REQ_READ, last_idx, $urandom_range(0, 31));
            end else begin
               send_request(ccas_pkg::REQ_READ, idx, $urandom_range(0, 31));
            end
            if (n == 290) send_request(ccas_pkg::REQ_STEP, idx, 0);
            // hold off once until the response queue runs dry
            if (phase == 0 && n == 400) wait_idle();
         end
         wait_idle();
      end
   endtask

   initial begin
      foreach (grid_model[i]) grid_model[i] = '0;
      cfg_range = ccas_pkg::RANGE_RST;
      cfg_threshold = ccas_pkg::THR_RST;
      cfg_states = ccas_pkg::SC_RST;
      cfg_moore = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_generation_rules();
      test_random_traffic();
      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0)
         $display("cyclic_cellular_automaton_step_core regression: pass");
      else
         $display("cyclic_cellular_automaton_step_core regression: fail");
      $finish;
   end

endmodule
